// File: hw/rtl/ptuv_pkg.sv
// Shared types and constants for the projective texture uv generator.
// No dependencies.
package ptuv_pkg;
   localparam int unsigned FracBits = 16;
   localparam int unsigned UvShift  = 8;
   localparam int unsigned WordW    = 32;
   localparam int unsigned TexW     = 24;
   localparam int unsigned MatDepth = 9;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_MUL_A,
      ST_LD_MUL_B,
      ST_LD_STORE,
      ST_DIV_A,
      ST_DIV_B,
      ST_ROW_MUL_A,
      ST_ROW_MUL_B,
      ST_ROW_ADD,
      ST_DIV_U,
      ST_DIV_V,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic signed [WordW-1:0] num;
      logic signed [WordW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic fault;
      logic signed [WordW-1:0] quo;
   } div_rsp_type;
endpackage

// File: hw/rtl/ptuv_fxmul.sv
// Registered 16.16 multiply: 32x32 product, floor shift by 16, wrap.
// Depends on ptuv_pkg.
module ptuv_fxmul (
   input  logic clock,
   input  logic signed [ptuv_pkg::WordW-1:0] op_a,
   input  logic signed [ptuv_pkg::WordW-1:0] op_b,
   output logic signed [ptuv_pkg::WordW-1:0] prod
);
   logic signed [2*ptuv_pkg::WordW-1:0] full;
   logic signed [ptuv_pkg::WordW-1:0] prod_ff, prod_in;

   assign full    = op_a * op_b;
   assign prod_in = full[ptuv_pkg::FracBits +: ptuv_pkg::WordW];
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
   assign prod = prod_ff;
endmodule

// File: hw/rtl/ptuv_divider.sv
// Radix-2 restoring divider for (n << 16) / d with saturation.
// Depends on ptuv_pkg.
module ptuv_divider (
   input  logic clock,
   input  logic reset,
   input  ptuv_pkg::div_req_type req,
   output ptuv_pkg::div_rsp_type rsp
);
   localparam int unsigned DW = ptuv_pkg::WordW + ptuv_pkg::FracBits;
   localparam int unsigned CW = $clog2(DW + 1);

   logic busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [ptuv_pkg::WordW:0] rem_ff, rem_in;
   logic [ptuv_pkg::WordW-1:0] mag_d_ff, mag_d_in;
   logic neg_ff, neg_in, nneg_ff, nneg_in, zero_ff, zero_in;
   logic [ptuv_pkg::WordW:0] trial;
   logic [DW-1:0] n_mag;
   logic signed [ptuv_pkg::WordW-1:0] d_s;
   logic [DW:0] qsigned;
   logic over;
   logic signed [ptuv_pkg::WordW-1:0] quo;

   always_comb begin
      n_mag = {ptuv_pkg::FracBits'(0), req.num[ptuv_pkg::WordW-1]
               ? ptuv_pkg::WordW'(-req.num) : ptuv_pkg::WordW'(req.num)};
      n_mag = n_mag << ptuv_pkg::FracBits;
      d_s   = req.den;
      trial = {rem_ff[ptuv_pkg::WordW-1:0], dvd_ff[DW-1]} - {1'b0, mag_d_ff};
      busy_in = busy_ff; cnt_in = cnt_ff; dvd_in = dvd_ff; rem_in = rem_ff;
      mag_d_in = mag_d_ff; neg_in = neg_ff; nneg_in = nneg_ff; zero_in = zero_ff;
      done_in = 1'b0;
      if (req.start) begin
         busy_in  = 1'b1;
         cnt_in   = CW'(DW);
         dvd_in   = n_mag;
         rem_in   = '0;
         mag_d_in = d_s[ptuv_pkg::WordW-1] ? ptuv_pkg::WordW'(-d_s)
                                           : ptuv_pkg::WordW'(d_s);
         neg_in   = req.num[ptuv_pkg::WordW-1] ^ d_s[ptuv_pkg::WordW-1];
         nneg_in  = req.num[ptuv_pkg::WordW-1];
         zero_in  = (d_s == '0);
      end else if (busy_ff) begin
         if (!trial[ptuv_pkg::WordW]) begin
            rem_in = trial;
            dvd_in = {dvd_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[ptuv_pkg::WordW-1:0], dvd_ff[DW-1]};
            dvd_in = {dvd_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in; rem_ff <= rem_in; mag_d_ff <= mag_d_in;
      neg_ff <= neg_in; nneg_ff <= nneg_in; zero_ff <= zero_in;
   end

   always_comb begin
      qsigned = neg_ff ? (DW+1)'(-{1'b0, dvd_ff}) : {1'b0, dvd_ff};
      if (neg_ff)
         over = (dvd_ff > DW'({1'b1, {(ptuv_pkg::WordW-1){1'b0}}}));
      else
         over = (dvd_ff > DW'({1'b0, {(ptuv_pkg::WordW-1){1'b1}}}));
      if (zero_ff)
         quo = nneg_ff ? {1'b1, {(ptuv_pkg::WordW-1){1'b0}}}
                       : {1'b0, {(ptuv_pkg::WordW-1){1'b1}}};
      else if (over)
         quo = neg_ff ? {1'b1, {(ptuv_pkg::WordW-1){1'b0}}}
                      : {1'b0, {(ptuv_pkg::WordW-1){1'b1}}};
      else
         quo = qsigned[ptuv_pkg::WordW-1:0];
      rsp.done  = done_ff;
      rsp.fault = zero_ff | over;
      rsp.quo   = quo;
   end
endmodule

// File: hw/rtl/projective_texture_uv_generator.sv
// Projective texture uv generator: load computes the warp matrix, vertex
// yields texture u and v. Uses ptuv_pkg, ptuv_fxmul, ptuv_divider.
//
// req_ carries one item: opcode 0 loads origin and u/v basis vectors,
// opcode 1 is a vertex. A load produces no result; the nine matrix entries
// are formed one product pair at a time by one shared multiplier, and no
// new item is taken until all nine are stored. A vertex produces one rsp_
// item after four serial divisions on one shared 48-step restoring
// divider, with the row products formed between the second and third.
// req_tready is high only in idle. rsp_ holds its item until rsp_tready,
// and the block takes no new item until the result is taken. Reset clears
// the matrix to zero and returns to idle; a vertex before any load gives
// saturated u and v with the fault flag set. rsp_tlast copies req_tlast of
// the vertex.
module projective_texture_uv_generator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: pos_x, pos_y, pos_z, u_dx, u_dy, u_dz, v_dx, v_dy, v_dz
   input  logic [287:0] req_tdata,
   // tuser: opcode
   input  logic         req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: tex_u, tex_v
   output logic [47:0]  rsp_tdata,
   // tuser: divide_fault
   output logic         rsp_tuser,
   output logic         rsp_tlast
);
   localparam int unsigned W = ptuv_pkg::WordW;
   typedef logic signed [W-1:0] word_type;

   ptuv_pkg::state_type st_ff, st_in;
   word_type mat_ff [ptuv_pkg::MatDepth];
   word_type in_ff [9];
   word_type a_ff, b_ff, r_ff [3], acc_ff, qu_ff;
   logic [3:0] k_ff, k_in;
   logic [1:0] ri_ff, ri_in;
   logic last_ff, fault_ff, is_v_ff;
   logic [1:0] dsel_ff;
   word_type ma, mb, prod;
   ptuv_pkg::div_req_type dreq;
   ptuv_pkg::div_rsp_type drsp;
   logic [2*ptuv_pkg::TexW-1:0] out_ff;

   ptuv_fxmul u_mul (.clock(clock), .op_a(ma), .op_b(mb), .prod(prod));
   ptuv_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // load operand selection: entry k = A*B - C*D
   function automatic logic [3:0] sel(input logic [3:0] k, input logic second,
                                      input logic pos);
      logic [7:0] t;
      begin
         // indices: 0 px 1 py 2 pz 3 x10 4 y10 5 z10 6 x20 7 y20 8 z20
         case (k)
            4'd0: t = second ? 8'h1_8 : 8'h7_2;
            4'd1: t = second ? 8'h6_2 : 8'h0_8;
            4'd2: t = second ? 8'h0_7 : 8'h6_1;
            4'd3: t = second ? 8'h4_2 : 8'h1_5;
            4'd4: t = second ? 8'h0_5 : 8'h3_2;
            4'd5: t = second ? 8'h3_1 : 8'h0_4;
            4'd6: t = second ? 8'h7_5 : 8'h4_8;
            4'd7: t = second ? 8'h3_8 : 8'h6_5;
            4'd8: t = second ? 8'h6_4 : 8'h3_7;
            default: t = 8'h0_0;
         endcase
         sel = pos ? t[7:4] : t[3:0];
      end
   endfunction

   always_comb begin
      ma = '0;
      mb = '0;
      case (st_ff)
         ptuv_pkg::ST_LD_MUL_A: begin
            ma = in_ff[sel(k_ff, 1'b0, 1'b1)];
            mb = in_ff[sel(k_ff, 1'b0, 1'b0)];
         end
         ptuv_pkg::ST_LD_MUL_B: begin
            ma = in_ff[sel(k_ff, 1'b1, 1'b1)];
            mb = in_ff[sel(k_ff, 1'b1, 1'b0)];
         end
         ptuv_pkg::ST_ROW_MUL_A: begin
            ma = mat_ff[4'(3 * ri_ff)];
            mb = a_ff;
         end
         ptuv_pkg::ST_ROW_MUL_B: begin
            ma = mat_ff[4'(3 * ri_ff + 1)];
            mb = b_ff;
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   always_comb begin
      st_in = st_ff;
      k_in  = k_ff;
      ri_in = ri_ff;
      case (st_ff)
         ptuv_pkg::ST_IDLE:
            if (req_tvalid) begin
               st_in = req_tuser ? ptuv_pkg::ST_DIV_A : ptuv_pkg::ST_LD_MUL_A;
               k_in  = '0;
               ri_in = '0;
            end
         ptuv_pkg::ST_LD_MUL_A: st_in = ptuv_pkg::ST_LD_MUL_B;
         ptuv_pkg::ST_LD_MUL_B: st_in = ptuv_pkg::ST_LD_STORE;
         ptuv_pkg::ST_LD_STORE: begin
            k_in = k_ff + 4'd1;
            st_in = (k_ff == 4'(ptuv_pkg::MatDepth - 1)) ? ptuv_pkg::ST_IDLE
                                                         : ptuv_pkg::ST_LD_MUL_A;
         end
         ptuv_pkg::ST_DIV_A: st_in = ptuv_pkg::ST_DIV_WAIT;
         ptuv_pkg::ST_DIV_B: st_in = ptuv_pkg::ST_DIV_WAIT;
         ptuv_pkg::ST_DIV_U: st_in = ptuv_pkg::ST_DIV_WAIT;
         ptuv_pkg::ST_DIV_V: st_in = ptuv_pkg::ST_DIV_WAIT;
         ptuv_pkg::ST_DIV_WAIT:
            if (drsp.done) begin
               case (dsel_ff)
                  2'd0: st_in = ptuv_pkg::ST_DIV_B;
                  2'd1: st_in = ptuv_pkg::ST_ROW_MUL_A;
                  2'd2: st_in = ptuv_pkg::ST_DIV_V;
                  default: st_in = ptuv_pkg::ST_OUT;
               endcase
            end
         ptuv_pkg::ST_ROW_MUL_A: st_in = ptuv_pkg::ST_ROW_MUL_B;
         ptuv_pkg::ST_ROW_MUL_B: st_in = ptuv_pkg::ST_ROW_ADD;
         ptuv_pkg::ST_ROW_ADD: begin
            ri_in = ri_ff + 2'd1;
            st_in = (ri_ff == 2'd2) ? ptuv_pkg::ST_DIV_U : ptuv_pkg::ST_ROW_MUL_A;
         end
         ptuv_pkg::ST_OUT:
            if (rsp_tready) st_in = ptuv_pkg::ST_IDLE;
         default: st_in = ptuv_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      dreq.start = 1'b0;
      dreq.num   = '0;
      dreq.den   = '0;
      case (st_ff)
         ptuv_pkg::ST_DIV_A: begin
            dreq.start = 1'b1; dreq.num = in_ff[0]; dreq.den = in_ff[2];
         end
         ptuv_pkg::ST_DIV_B: begin
            dreq.start = 1'b1; dreq.num = in_ff[1]; dreq.den = in_ff[2];
         end
         ptuv_pkg::ST_DIV_U: begin
            dreq.start = 1'b1; dreq.num = r_ff[0]; dreq.den = r_ff[2];
         end
         ptuv_pkg::ST_DIV_V: begin
            dreq.start = 1'b1; dreq.num = r_ff[1]; dreq.den = r_ff[2];
         end
         default: dreq.start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ptuv_pkg::ST_IDLE;
         k_ff  <= '0;
         ri_ff <= '0;
         for (int i = 0; i < ptuv_pkg::MatDepth; i++) mat_ff[i] <= '0;
      end else begin
         st_ff <= st_in;
         k_ff  <= k_in;
         ri_ff <= ri_in;
         if (st_ff == ptuv_pkg::ST_LD_STORE) mat_ff[k_ff] <= acc_ff - prod;
      end
      if (st_ff == ptuv_pkg::ST_IDLE && req_tvalid) begin
         for (int i = 0; i < 9; i++) in_ff[i] <= req_tdata[32*i +: 32];
         last_ff  <= req_tlast;
         fault_ff <= 1'b0;
         is_v_ff  <= req_tuser;
      end
      case (st_ff)
         ptuv_pkg::ST_LD_MUL_B:  acc_ff <= prod;
         ptuv_pkg::ST_ROW_MUL_B: acc_ff <= prod;
         ptuv_pkg::ST_ROW_ADD:   r_ff[ri_ff] <= acc_ff + prod + mat_ff[4'(3 * ri_ff + 2)];
         ptuv_pkg::ST_DIV_A:     dsel_ff <= 2'd0;
         ptuv_pkg::ST_DIV_B:     dsel_ff <= 2'd1;
         ptuv_pkg::ST_DIV_U:     dsel_ff <= 2'd2;
         ptuv_pkg::ST_DIV_V:     dsel_ff <= 2'd3;
         ptuv_pkg::ST_DIV_WAIT:
            if (drsp.done) begin
               fault_ff <= fault_ff | drsp.fault;
               case (dsel_ff)
                  2'd0: a_ff <= drsp.quo;
                  2'd1: b_ff <= drsp.quo;
                  2'd2: qu_ff <= drsp.quo;
                  default: out_ff <= {drsp.quo[W-1:ptuv_pkg::UvShift],
                                      qu_ff[W-1:ptuv_pkg::UvShift]};
               endcase
            end
         default: ;
      endcase
   end

   assign req_tready = (st_ff == ptuv_pkg::ST_IDLE);
   assign rsp_tvalid = (st_ff == ptuv_pkg::ST_OUT) & is_v_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = fault_ff;
   assign rsp_tlast  = last_ff;
endmodule
